FILE: hw/rtl/keyframe_track_lerp_engine_top_assert.svh
// Assertion macros for the keyframe track interpolation engine checker.
// Needs no other file; the checker includes it by name.
`ifndef KEYFRAME_TRACK_LERP_ENGINE_TOP_ASSERT_SVH
`define KEYFRAME_TRACK_LERP_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KLE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("keyframe engine assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("keyframe engine assertion failed");

`endif

FILE: hw/rtl/kle_pkg.sv
// Shared constants of the keyframe track interpolation engine.
// Used by the channel interfaces, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none
package kle_pkg;
	localparam int TIME_W = 32;
	localparam int VAL_W  = 32;
	localparam int KEY_W  = TIME_W + 3 * VAL_W;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_SAMPLE = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_TRACK   = 3'd1;
	localparam logic [2:0] ST_FULL        = 3'd2;
	localparam logic [2:0] ST_NO_KEYS     = 3'd3;
	localparam logic [2:0] ST_EQUAL_TIMES = 3'd4;
endpackage
`default_nettype wire

FILE: hw/rtl/kle_req_if.sv
// Request channel of the keyframe track interpolation engine.
// Depends on kle_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface kle_req_if;
	logic                             valid;
	logic                             ready;
	logic [1:0]                       mode;
	logic [3:0]                       track_index;
	logic                             channel;
	logic [kle_pkg::TIME_W-1:0]       time_req;
	logic signed [kle_pkg::VAL_W-1:0] value_x;
	logic signed [kle_pkg::VAL_W-1:0] value_y;
	logic signed [kle_pkg::VAL_W-1:0] value_z;
	logic                             overwrite;

	modport source (output valid, mode, track_index, channel, time_req, value_x, value_y,
		value_z, overwrite, input ready);
	modport sink (input valid, mode, track_index, channel, time_req, value_x, value_y,
		value_z, overwrite, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/kle_rsp_if.sv
// Response channel of the keyframe track interpolation engine.
// Depends on kle_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface kle_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [2:0]                       status;
	logic [5:0]                       key_position;
	logic                             has_value;
	logic signed [kle_pkg::VAL_W-1:0] result_x;
	logic signed [kle_pkg::VAL_W-1:0] result_y;
	logic signed [kle_pkg::VAL_W-1:0] result_z;

	modport source (output valid, status, key_position, has_value, result_x, result_y,
		result_z, input ready);
	modport sink (input valid, status, key_position, has_value, result_x, result_y,
		result_z, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/kle_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module kle_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

FILE: hw/rtl/kle_lerp.sv
// One interpolation lane: a + trunc(|b - a| * num / den) with the sign of b - a.
// A multiply state, then a 32-step restoring divider; depends on kle_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kle_lerp (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [kle_pkg::VAL_W-1:0]        a,
	input  wire logic [kle_pkg::VAL_W-1:0]        b,
	input  wire logic [kle_pkg::TIME_W-1:0]       num,
	input  wire logic [kle_pkg::TIME_W-1:0]       den,
	output logic                                  done,
	output logic signed [kle_pkg::VAL_W-1:0]      res
);
	typedef enum logic [1:0] {L_IDLE, L_MUL, L_DIV, L_FIN} lstate_t;

	lstate_t     state_q;
	logic [31:0] a_q, mag_q, num_q, den_q, rem_q, low_q, quo_q;
	logic        neg_q, done_q;
	logic [4:0]  it_q;
	logic signed [31:0] res_q;

	logic [32:0] diff, diff_n, trial;
	logic [63:0] prod;
	logic [33:0] sum;

	always_comb begin
		diff   = {b[31], b} - {a[31], a};
		diff_n = ~diff + 33'd1;
		prod   = mag_q * num_q;
		trial  = {rem_q, low_q[31]};
		sum    = neg_q ? ({{2{a_q[31]}}, a_q} - {2'b00, quo_q})
			: ({{2{a_q[31]}}, a_q} + {2'b00, quo_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
			it_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						a_q     <= a;
						neg_q   <= diff[32];
						mag_q   <= diff[32] ? diff_n[31:0] : diff[31:0];
						num_q   <= num;
						den_q   <= den;
						state_q <= L_MUL;
					end
				end
				L_MUL: begin
					rem_q   <= prod[63:32];
					low_q   <= prod[31:0];
					quo_q   <= '0;
					it_q    <= '0;
					state_q <= L_DIV;
				end
				L_DIV: begin
					if (trial >= {1'b0, den_q}) begin
						rem_q <= 32'(trial - {1'b0, den_q});
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= trial[31:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end
					low_q <= {low_q[30:0], 1'b0};
					it_q  <= it_q + 5'd1;
					if (it_q == 5'd31) begin
						state_q <= L_FIN;
					end
				end
				L_FIN: begin
					if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
						res_q <= sum[31:0];
					end else if (sum[33]) begin
						res_q <= 32'h8000_0000;
					end else begin
						res_q <= 32'h7FFF_FFFF;
					end
					done_q  <= 1'b1;
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign res  = res_q;
endmodule
`default_nettype wire

FILE: hw/rtl/keyframe_track_lerp_engine_top.sv
// Top level of the keyframe track interpolation engine: sequencer, key and count memories.
// Depends on kle_pkg, kle_req_if, kle_rsp_if, kle_ram and kle_lerp.
`timescale 1ns / 1ps
`default_nettype none
// The engine handles one transaction at a time over a key memory with one write port and one
// registered read port. After reset, and for every clear, a pass writes zero to each key count,
// one table per cycle (2 * MAX_TRACKS rounded up to a power of two tables, 32 by default); no
// transaction is accepted during the reset pass. Each binary search probe reads a key and then
// compares its time. An insert of a new key searches, then moves each later key up one slot,
// and each nudge of an equal time repeats the search. A sample that interpolates waits for the
// bit-serial dividers of the three lanes. A finished result sits in an output register, so the
// next transaction can start while it waits to be taken.
module keyframe_track_lerp_engine_top #(
	parameter int MAX_TRACKS     = 16,
	parameter int KEYS_PER_TABLE = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	kle_req_if.sink         req,
	kle_rsp_if.source       rsp,
	input  wire logic       cfg_we,
	input  wire logic [4:0] cfg_wdata
);
	localparam int TABLES = 2 * MAX_TRACKS;
	localparam int TAB_W  = $clog2(TABLES);
	localparam int SLOT_W = $clog2(KEYS_PER_TABLE);
	localparam int CNT_W  = $clog2(KEYS_PER_TABLE + 1);
	localparam int ADDR_W = TAB_W + SLOT_W;
	localparam int KW     = kle_pkg::KEY_W;

	typedef enum logic [3:0] {
		S_IDLE, S_CLR, S_CNT_RD, S_CNT_USE, S_SRCH_RD, S_SRCH_CMP, S_POST, S_PROBE_CHK,
		S_NEWKEY, S_SH_RD, S_SH_WR, S_SMP_EDGE, S_SMP_A, S_SMP_B, S_LERP, S_RESP
	} state_t;

	state_t             state_q;
	logic [4:0]         tracks_q;
	logic               clr_rsp_q;
	logic [TAB_W-1:0]   clr_q, tab_q;
	logic [1:0]         mode_q;
	logic [31:0]        t_q, vx_q, vy_q, vz_q;
	logic               ow_q;
	logic [CNT_W-1:0]   cnt_q, lo_q, hi_q, i_q;
	logic [KW-1:0]      a_q;
	logic [2:0]         st_q;
	logic [SLOT_W-1:0]  pos_q;
	logic               has_q;
	logic [31:0]        rx_q, ry_q, rz_q;

	logic               out_valid_q, out_has_q;
	logic [2:0]         out_st_q;
	logic [5:0]         out_pos_q;
	logic [31:0]        out_x_q, out_y_q, out_z_q;

	logic               key_we, cnt_we;
	logic [ADDR_W-1:0]  key_waddr, key_raddr;
	logic [KW-1:0]      key_wdata, key_rdata;
	logic [TAB_W-1:0]   cnt_waddr, cnt_raddr;
	logic [CNT_W-1:0]   cnt_wdata, cnt_rdata;

	logic [TAB_W+4:0]   tab_ext;
	logic               bad_track;
	logic [CNT_W:0]     mid_sum;
	logic [CNT_W-1:0]   mid, lo_m1, cnt_m1, i_m1, cnt_p1;
	logic [31:0]        ta, tb, rd_time;
	logic               lerp_start;
	logic [2:0]         lane_done;
	logic [31:0]        lane_x, lane_y, lane_z;
	logic [SLOT_W+5:0]  pos_ext;

	always_comb begin
		tab_ext   = {{TAB_W{1'b0}}, req.track_index, req.channel};
		bad_track = ({1'b0, req.track_index} >= tracks_q)
			|| ({28'd0, req.track_index} >= 32'(MAX_TRACKS));
		mid_sum   = {1'b0, lo_q} + {1'b0, hi_q};
		mid       = mid_sum[CNT_W:1];
		lo_m1     = lo_q - 1'b1;
		cnt_m1    = cnt_q - 1'b1;
		i_m1      = i_q - 1'b1;
		cnt_p1    = cnt_q + 1'b1;
		rd_time   = key_rdata[KW-1 -: 32];
		ta        = a_q[KW-1 -: 32];
		tb        = rd_time;
		lerp_start = (state_q == S_SMP_B) && (tb > ta);
		pos_ext   = {6'd0, pos_q};
	end

	always_comb begin
		key_we    = 1'b0;
		key_waddr = {tab_q, i_q[SLOT_W-1:0]};
		key_wdata = key_rdata;
		key_raddr = {tab_q, mid[SLOT_W-1:0]};
		cnt_we    = 1'b0;
		cnt_waddr = tab_q;
		cnt_wdata = cnt_p1;
		cnt_raddr = tab_q;
		unique case (state_q)
			S_CLR: begin
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
				cnt_wdata = '0;
			end
			S_POST: begin
				if (mode_q == kle_pkg::MODE_SAMPLE && lo_q >= cnt_q) begin
					key_raddr = {tab_q, cnt_m1[SLOT_W-1:0]};
				end else if (lo_q == '0) begin
					key_raddr = {tab_q, {SLOT_W{1'b0}}};
				end else begin
					key_raddr = {tab_q, lo_m1[SLOT_W-1:0]};
				end
			end
			S_PROBE_CHK: begin
				if (rd_time == t_q && ow_q) begin
					key_we    = 1'b1;
					key_waddr = {tab_q, lo_m1[SLOT_W-1:0]};
					key_wdata = {t_q, vx_q, vy_q, vz_q};
				end
			end
			S_SH_RD: begin
				key_raddr = {tab_q, i_m1[SLOT_W-1:0]};
				if (i_q <= lo_q) begin
					key_we    = 1'b1;
					key_waddr = {tab_q, lo_q[SLOT_W-1:0]};
					key_wdata = {t_q, vx_q, vy_q, vz_q};
					cnt_we    = 1'b1;
				end
			end
			S_SH_WR: begin
				key_we = 1'b1;
			end
			S_SMP_A: begin
				key_raddr = {tab_q, lo_q[SLOT_W-1:0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			tracks_q    <= '0;
			clr_q       <= '0;
			clr_rsp_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				tracks_q <= cfg_wdata;
			end
			if (state_q == S_RESP && (!out_valid_q || rsp.ready)) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						mode_q <= req.mode;
						tab_q  <= tab_ext[TAB_W-1:0];
						t_q    <= req.time_req;
						vx_q   <= req.value_x;
						vy_q   <= req.value_y;
						vz_q   <= req.value_z;
						ow_q   <= req.overwrite;
						st_q   <= kle_pkg::ST_OK;
						pos_q  <= '0;
						has_q  <= 1'b0;
						rx_q   <= '0;
						ry_q   <= '0;
						rz_q   <= '0;
						if (req.mode == kle_pkg::MODE_CLEAR) begin
							clr_q     <= '0;
							clr_rsp_q <= 1'b1;
							state_q   <= S_CLR;
						end else if (req.mode != kle_pkg::MODE_INSERT
							&& req.mode != kle_pkg::MODE_SAMPLE) begin
							state_q <= S_RESP;
						end else if (bad_track) begin
							st_q    <= kle_pkg::ST_BAD_TRACK;
							state_q <= S_RESP;
						end else begin
							state_q <= S_CNT_RD;
						end
					end
				end
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == {TAB_W{1'b1}}) begin
						state_q <= clr_rsp_q ? S_RESP : S_IDLE;
					end
				end
				S_CNT_RD: state_q <= S_CNT_USE;
				S_CNT_USE: begin
					cnt_q <= cnt_rdata;
					lo_q  <= '0;
					hi_q  <= cnt_rdata;
					if (mode_q == kle_pkg::MODE_SAMPLE && cnt_rdata == '0) begin
						st_q    <= kle_pkg::ST_NO_KEYS;
						state_q <= S_RESP;
					end else begin
						state_q <= S_SRCH_RD;
					end
				end
				S_SRCH_RD: state_q <= (lo_q < hi_q) ? S_SRCH_CMP : S_POST;
				S_SRCH_CMP: begin
					if (rd_time <= t_q) begin
						lo_q <= mid + 1'b1;
					end else begin
						hi_q <= mid;
					end
					state_q <= S_SRCH_RD;
				end
				S_POST: begin
					if (mode_q == kle_pkg::MODE_SAMPLE) begin
						if (lo_q >= cnt_q) begin
							pos_q   <= cnt_m1[SLOT_W-1:0];
							state_q <= S_SMP_EDGE;
						end else if (lo_q == '0) begin
							pos_q   <= '0;
							state_q <= S_SMP_EDGE;
						end else begin
							pos_q   <= lo_m1[SLOT_W-1:0];
							state_q <= S_SMP_A;
						end
					end else begin
						state_q <= (lo_q == '0) ? S_NEWKEY : S_PROBE_CHK;
					end
				end
				S_PROBE_CHK: begin
					if (rd_time != t_q) begin
						state_q <= S_NEWKEY;
					end else if (ow_q) begin
						pos_q   <= lo_m1[SLOT_W-1:0];
						state_q <= S_RESP;
					end else if (t_q == 32'hFFFF_FFFF) begin
						st_q    <= kle_pkg::ST_EQUAL_TIMES;
						state_q <= S_RESP;
					end else begin
						t_q     <= t_q + 32'd1;
						lo_q    <= '0;
						hi_q    <= cnt_q;
						state_q <= S_SRCH_RD;
					end
				end
				S_NEWKEY: begin
					if (cnt_q >= CNT_W'(KEYS_PER_TABLE)) begin
						st_q    <= kle_pkg::ST_FULL;
						state_q <= S_RESP;
					end else begin
						i_q     <= cnt_q;
						state_q <= S_SH_RD;
					end
				end
				S_SH_RD: begin
					if (i_q > lo_q) begin
						state_q <= S_SH_WR;
					end else begin
						pos_q   <= lo_q[SLOT_W-1:0];
						state_q <= S_RESP;
					end
				end
				S_SH_WR: begin
					i_q     <= i_m1;
					state_q <= S_SH_RD;
				end
				S_SMP_EDGE: begin
					rx_q    <= key_rdata[95:64];
					ry_q    <= key_rdata[63:32];
					rz_q    <= key_rdata[31:0];
					has_q   <= 1'b1;
					state_q <= S_RESP;
				end
				S_SMP_A: begin
					a_q     <= key_rdata;
					state_q <= S_SMP_B;
				end
				S_SMP_B: begin
					if (tb > ta) begin
						state_q <= S_LERP;
					end else begin
						st_q    <= kle_pkg::ST_EQUAL_TIMES;
						pos_q   <= '0;
						state_q <= S_RESP;
					end
				end
				S_LERP: begin
					if (&lane_done) begin
						rx_q    <= lane_x;
						ry_q    <= lane_y;
						rz_q    <= lane_z;
						has_q   <= 1'b1;
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					if (!out_valid_q || rsp.ready) begin
						out_st_q    <= st_q;
						out_pos_q   <= pos_ext[5:0];
						out_has_q   <= has_q;
						out_x_q     <= rx_q;
						out_y_q     <= ry_q;
						out_z_q     <= rz_q;
						clr_rsp_q   <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	kle_ram #(.WIDTH(KW), .DEPTH(2 ** ADDR_W)) u_key_ram (
		.clk(clk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
		.raddr(key_raddr), .rdata(key_rdata)
	);

	kle_ram #(.WIDTH(CNT_W), .DEPTH(2 ** TAB_W)) u_cnt_ram (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	kle_lerp u_lerp_x (
		.clk(clk), .arst_n(arst_n), .start(lerp_start), .a(a_q[95:64]),
		.b(key_rdata[95:64]), .num(t_q - ta), .den(tb - ta), .done(lane_done[0]),
		.res(lane_x)
	);

	kle_lerp u_lerp_y (
		.clk(clk), .arst_n(arst_n), .start(lerp_start), .a(a_q[63:32]),
		.b(key_rdata[63:32]), .num(t_q - ta), .den(tb - ta), .done(lane_done[1]),
		.res(lane_y)
	);

	kle_lerp u_lerp_z (
		.clk(clk), .arst_n(arst_n), .start(lerp_start), .a(a_q[31:0]),
		.b(key_rdata[31:0]), .num(t_q - ta), .den(tb - ta), .done(lane_done[2]),
		.res(lane_z)
	);

	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_st_q;
	assign rsp.key_position = out_pos_q;
	assign rsp.has_value    = out_has_q;
	assign rsp.result_x     = out_x_q;
	assign rsp.result_y     = out_y_q;
	assign rsp.result_z     = out_z_q;
endmodule
`default_nettype wire

FILE: hw/rtl/kle_checker.sv
// Port-level checker for the keyframe track interpolation engine, bound to the top level.
// Depends on kle_pkg and keyframe_track_lerp_engine_top_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "keyframe_track_lerp_engine_top_assert.svh"
module kle_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [2:0]  status,
	input wire logic        has_value,
	input wire logic [31:0] result_x,
	input wire logic [31:0] result_y,
	input wire logic [31:0] result_z
);
	`KLE_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(result_x))
	`KLE_ASSERT_NOW(a_status_range, clk, arst_n, rsp_valid, status <= kle_pkg::ST_EQUAL_TIMES)
	`KLE_ASSERT_NOW(a_value_ok, clk, arst_n, rsp_valid && has_value, status == kle_pkg::ST_OK)
	`KLE_ASSERT_NOW(a_no_value_zero, clk, arst_n, rsp_valid && !has_value, result_x == 32'd0 && result_y == 32'd0 && result_z == 32'd0)
endmodule

bind keyframe_track_lerp_engine_top kle_checker u_kle_checker (
	.clk(clk), .arst_n(arst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.status(rsp.status), .has_value(rsp.has_value), .result_x(rsp.result_x),
	.result_y(rsp.result_y), .result_z(rsp.result_z)
);
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the keyframe track interpolation engine.
// It needs kle_pkg, kle_req_if, kle_rsp_if and keyframe_track_lerp_engine_top.
// It predicts every transaction in a scoreboard class and checks each response.
`timescale 1ns / 1ps

module testbench;
	localparam int N_TRACKS = 16;
	localparam int N_KEYS = 64;
	localparam int N_TABLES = 2 * N_TRACKS;
	localparam int STALL_LIMIT = 8000;
	localparam int SETTLE_CYCLES = 200;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] key_position;
		logic has_value;
		logic [31:0] res_x;
		logic [31:0] res_y;
		logic [31:0] res_z;
	} track_answer_t;

	class keyframe_scoreboard;
		logic [4:0] tracks_in_use;
		int unsigned key_total[N_TABLES];
		logic [31:0] key_time[N_TABLES * N_KEYS];
		logic [31:0] key_x[N_TABLES * N_KEYS];
		logic [31:0] key_y[N_TABLES * N_KEYS];
		logic [31:0] key_z[N_TABLES * N_KEYS];
		track_answer_t pending[$];
		int mismatches;
		int checked;
		int interpolated;
		int full_hits;
		int nudge_fails;

		function void clear_all();
			foreach (key_total[i])
				key_total[i] = 0;
		endfunction

		function int unsigned count_not_after(int unsigned base, int unsigned cnt,
			logic [31:0] t);
			int unsigned lo;
			int unsigned hi;
			int unsigned mid;
			lo = 0;
			hi = cnt;
			while (lo < hi) begin
				mid = (lo + hi) >> 1;
				if (key_time[base + mid] <= t)
					lo = mid + 1;
				else
					hi = mid;
			end
			return lo;
		endfunction

		function logic [31:0] blend(logic [31:0] ua, logic [31:0] ub, logic [31:0] num,
			logic [31:0] den);
			longint a;
			longint b;
			longint d;
			longint r;
			logic [63:0] mag;
			logic [63:0] q;
			a = longint'(signed'(ua));
			b = longint'(signed'(ub));
			d = b - a;
			mag = (d < 0) ? -d : d;
			q = (mag * {32'd0, num}) / {32'd0, den};
			r = (d < 0) ? a - longint'(q) : a + longint'(q);
			if (r > 64'sd2147483647)
				r = 64'sd2147483647;
			if (r < -64'sd2147483648)
				r = -64'sd2147483648;
			return r[31:0];
		endfunction

		function void note_request(logic [1:0] mode, logic [3:0] trk, logic ch,
			logic [31:0] t_in, logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic ow);
			track_answer_t ans;
			int unsigned tab;
			int unsigned base;
			int unsigned cnt;
			int unsigned n;
			int unsigned s;
			logic [31:0] t;
			bit exact;
			bit fail;
			ans = '0;
			t = t_in;
			if (mode == kle_pkg::MODE_CLEAR) begin
				clear_all();
			end else if (mode == kle_pkg::MODE_INSERT || mode == kle_pkg::MODE_SAMPLE) begin
				if (trk >= tracks_in_use) begin
					ans.status = kle_pkg::ST_BAD_TRACK;
				end else begin
					tab = trk * 2 + ch;
					base = tab * N_KEYS;
					cnt = key_total[tab];
					if (mode == kle_pkg::MODE_INSERT) begin
						n = count_not_after(base, cnt, t);
						exact = n > 0 && key_time[base + n - 1] == t;
						fail = 0;
						while (exact && !ow) begin
							if (t == 32'hFFFF_FFFF) begin
								fail = 1;
								break;
							end
							t++;
							n = count_not_after(base, cnt, t);
							exact = n > 0 && key_time[base + n - 1] == t;
						end
						if (fail) begin
							ans.status = kle_pkg::ST_EQUAL_TIMES;
							nudge_fails++;
						end else if (exact) begin
							s = base + n - 1;
							key_x[s] = vx;
							key_y[s] = vy;
							key_z[s] = vz;
							ans.key_position = n - 1;
						end else if (cnt >= N_KEYS) begin
							ans.status = kle_pkg::ST_FULL;
							full_hits++;
						end else begin
							for (int unsigned i = cnt; i > n; i--) begin
								key_time[base + i] = key_time[base + i - 1];
								key_x[base + i] = key_x[base + i - 1];
								key_y[base + i] = key_y[base + i - 1];
								key_z[base + i] = key_z[base + i - 1];
							end
							key_time[base + n] = t;
							key_x[base + n] = vx;
							key_y[base + n] = vy;
							key_z[base + n] = vz;
							key_total[tab] = cnt + 1;
							ans.key_position = n;
						end
					end else if (cnt == 0) begin
						ans.status = kle_pkg::ST_NO_KEYS;
					end else begin
						n = count_not_after(base, cnt, t);
						if (n == 0 || n >= cnt) begin
							s = (n == 0) ? 0 : cnt - 1;
							ans.res_x = key_x[base + s];
							ans.res_y = key_y[base + s];
							ans.res_z = key_z[base + s];
							ans.key_position = s;
							ans.has_value = 1;
						end else if (key_time[base + n] <= key_time[base + n - 1]) begin
							ans.status = kle_pkg::ST_EQUAL_TIMES;
						end else begin
							s = base + n - 1;
							ans.res_x = blend(key_x[s], key_x[s + 1], t - key_time[s],
								key_time[s + 1] - key_time[s]);
							ans.res_y = blend(key_y[s], key_y[s + 1], t - key_time[s],
								key_time[s + 1] - key_time[s]);
							ans.res_z = blend(key_z[s], key_z[s + 1], t - key_time[s],
								key_time[s + 1] - key_time[s]);
							ans.key_position = n - 1;
							ans.has_value = 1;
							interpolated++;
						end
					end
				end
			end
			pending = {pending, ans};
		endfunction

		function void check_response(track_answer_t got);
			track_answer_t want;
			checked++;
			if (pending.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected response %p", $time, got);
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status) begin
				mismatches++;
				$display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
			end
			if (got.key_position !== want.key_position) begin
				mismatches++;
				$display("%0t: key_position expected %0d actual %0d", $time, want.key_position,
					got.key_position);
			end
			if (got.has_value !== want.has_value) begin
				mismatches++;
				$display("%0t: has_value expected %0d actual %0d", $time, want.has_value,
					got.has_value);
			end
			if (got.res_x !== want.res_x) begin
				mismatches++;
				$display("%0t: result_x expected %h actual %h", $time, want.res_x, got.res_x);
			end
			if (got.res_y !== want.res_y) begin
				mismatches++;
				$display("%0t: result_y expected %h actual %h", $time, want.res_y, got.res_y);
			end
			if (got.res_z !== want.res_z) begin
				mismatches++;
				$display("%0t: result_z expected %h actual %h", $time, want.res_z, got.res_z);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [4:0] cfg_wdata;
	bit quiet;
	int idle_cycles;
	int sent;
	keyframe_scoreboard track_model;

	kle_req_if req_ch();
	kle_rsp_if rsp_ch();

	keyframe_track_lerp_engine_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				track_model.note_request(req_ch.mode, req_ch.track_index, req_ch.channel,
					req_ch.time_req, req_ch.value_x, req_ch.value_y, req_ch.value_z,
					req_ch.overwrite);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				track_model.check_response({rsp_ch.status, rsp_ch.key_position,
					rsp_ch.has_value, rsp_ch.result_x, rsp_ch.result_y, rsp_ch.result_z});
			end
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		int w;
		rsp_ch.ready <= 0;
		@(posedge arst_n);
		forever begin
			w = quiet ? 0 : $urandom_range(0, 7);
			if (w > 0) begin
				rsp_ch.ready <= 0;
				repeat (w) @(posedge clk);
			end
			rsp_ch.ready <= 1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	task automatic send_item(logic [1:0] mode, logic [3:0] trk, logic ch, logic [31:0] t,
		logic [31:0] vx, logic [31:0] vy, logic [31:0] vz, logic ow);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			req_ch.valid <= 0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1;
		req_ch.mode <= mode;
		req_ch.track_index <= trk;
		req_ch.channel <= ch;
		req_ch.time_req <= t;
		req_ch.value_x <= vx;
		req_ch.value_y <= vy;
		req_ch.value_z <= vz;
		req_ch.overwrite <= ow;
		do @(posedge clk); while (!req_ch.ready);
		sent++;
	endtask

	task automatic drain();
		req_ch.valid <= 0;
		while (track_model.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_tracks(logic [4:0] v);
		drain();
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
		track_model.tracks_in_use = v;
	endtask

	function automatic logic [31:0] pick_time();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return ($urandom_range(0, 40) << 12) + $urandom_range(0, 2);
		else if (r < 80)
			return 32'hFFFF_FFFF - $urandom_range(0, 3);
		else
			return $urandom;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_phase(int items, logic [4:0] tracks);
		int r;
		logic [1:0] mode;
		logic [3:0] trk;
		for (int i = 0; i < items; i++) begin
			r = $urandom_range(0, 99);
			if (r < 2)
				mode = kle_pkg::MODE_CLEAR;
			else if (r < 4)
				mode = 2'd3;
			else if (r < 50)
				mode = kle_pkg::MODE_INSERT;
			else
				mode = kle_pkg::MODE_SAMPLE;
			if (tracks != 0 && $urandom_range(0, 99) < 85)
				trk = $urandom_range(0, (tracks > 16 ? 16 : tracks) - 1);
			else
				trk = $urandom_range(0, 15);
			send_item(mode, trk, $urandom_range(0, 1), pick_time(), pick_value(),
				pick_value(), pick_value(), $urandom_range(0, 1));
		end
	endtask

	initial begin
		logic [4:0] phase_tracks[6];
		int phase_items[6];
		phase_tracks = '{5'd11, 5'd16, 5'd1, 5'd7, 5'd0, 5'd16};
		phase_items = '{80, 50, 50, 70, 20, 80};
		track_model = new();
		track_model.tracks_in_use = 0;
		track_model.clear_all();
		arst_n = 0;
		cfg_we <= 0;
		cfg_wdata <= 0;
		req_ch.valid <= 0;
		req_ch.mode <= kle_pkg::MODE_INSERT;
		req_ch.track_index <= 0;
		req_ch.channel <= 0;
		req_ch.time_req <= 0;
		req_ch.value_x <= 0;
		req_ch.value_y <= 0;
		req_ch.value_z <= 0;
		req_ch.overwrite <= 0;
		quiet = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		send_item(kle_pkg::MODE_SAMPLE, 4'd0, 1'b0, 32'h0001_0000, 0, 0, 0, 1'b0);
		send_item(kle_pkg::MODE_INSERT, 4'd0, 1'b0, 32'h0001_0000, 1, 1, 1, 1'b0);
		write_tracks(5'd16);
		quiet = 0;
		send_item(kle_pkg::MODE_SAMPLE, 4'd0, 1'b0, 32'h0000_0000, 0, 0, 0, 1'b0);
		send_item(kle_pkg::MODE_INSERT, 4'd0, 1'b0, 32'h0001_0000, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0000_0000, 1'b0);
		send_item(kle_pkg::MODE_INSERT, 4'd0, 1'b0, 32'h0003_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_item(kle_pkg::MODE_SAMPLE, 4'd0, 1'b0, 32'h0000_0000, 0, 0, 0, 1'b0);
		send_item(kle_pkg::MODE_SAMPLE, 4'd0, 1'b0, 32'h0002_0000, 0, 0, 0, 1'b0);
		send_item(kle_pkg::MODE_SAMPLE, 4'd0, 1'b0, 32'h0002_8001, 0, 0, 0, 1'b0);
		send_item(kle_pkg::MODE_SAMPLE, 4'd0, 1'b0, 32'hFFFF_FFFF, 0, 0, 0, 1'b0);
		send_item(kle_pkg::MODE_INSERT, 4'd0, 1'b0, 32'h0001_0000, 32'h0001_0000,
			32'h0002_0000, 32'h0003_0000, 1'b1);
		send_item(kle_pkg::MODE_INSERT, 4'd0, 1'b0, 32'h0001_0000, 5, 6, 7, 1'b0);
		send_item(kle_pkg::MODE_INSERT, 4'd0, 1'b0, 32'hFFFF_FFFF, 8, 9, 10, 1'b0);
		send_item(kle_pkg::MODE_INSERT, 4'd0, 1'b0, 32'hFFFF_FFFF, 11, 12, 13, 1'b0);
		send_item(kle_pkg::MODE_SAMPLE, 4'd0, 1'b0, 32'h8000_0000, 0, 0, 0, 1'b0);
		send_item(kle_pkg::MODE_INSERT, 4'd15, 1'b1, 32'h0000_0000, 32'hFFFF_FFFF,
			32'h1234_5678, 32'h8000_0001, 1'b1);
		send_item(kle_pkg::MODE_SAMPLE, 4'd15, 1'b1, 32'h0000_0000, 0, 0, 0, 1'b0);
		send_item(2'd3, 4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 1'b1);
		send_item(kle_pkg::MODE_CLEAR, 4'd0, 1'b0, 32'h0, 0, 0, 0, 1'b0);
		send_item(kle_pkg::MODE_SAMPLE, 4'd0, 1'b0, 32'h0001_0000, 0, 0, 0, 1'b0);
		send_item(kle_pkg::MODE_INSERT, 4'd15, 1'b0, 32'h0000_0001, 1, 2, 3, 1'b0);

		for (int p = 0; p < 6; p++) begin
			write_tracks(phase_tracks[p]);
			quiet = (p % 2 == 1);
			if (phase_tracks[p] == 16 && p == 1) begin
				for (int i = 0; i < 70; i++)
					send_item(kle_pkg::MODE_INSERT, 4'd3, 1'b1, pick_time(), pick_value(),
						pick_value(), pick_value(), i >= 66);
				for (int i = 0; i < 8; i++)
					send_item(kle_pkg::MODE_SAMPLE, 4'd3, 1'b1, pick_time(), 0, 0, 0, 1'b0);
			end
			random_phase(phase_items[p], phase_tracks[p]);
		end

		drain();
		$display("Ran %0d transactions through %0d tracks settings; %0d interpolated samples,",
			sent, 7, track_model.interpolated);
		$display("%0d full-table rejects, %0d nudge rejects, %0d responses checked.",
			track_model.full_hits, track_model.nudge_fails, track_model.checked);
		if (track_model.mismatches == 0 && track_model.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
